### sv/cva_pkg.sv
// Shared types, constants and the arctangent table of the CORDIC angle finder.
package cva_pkg;

	localparam int IN_WIDTH    = 16;
	localparam int ANGLE_WIDTH = 15;
	localparam int TABLE_LEN   = 10;

	typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	// atan(2^-idx) in hundredths of a degree.
	function automatic angle_t atan_entry(input logic [3:0] idx);
		angle_t val;
		unique case (idx)
			4'd0:    val = 15'sd4500;
			4'd1:    val = 15'sd2657;
			4'd2:    val = 15'sd1404;
			4'd3:    val = 15'sd713;
			4'd4:    val = 15'sd358;
			4'd5:    val = 15'sd179;
			4'd6:    val = 15'sd90;
			4'd7:    val = 15'sd45;
			4'd8:    val = 15'sd22;
			4'd9:    val = 15'sd11;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

### sv/cordic_vectoring_angle.sv
// Bit-serial CORDIC vectoring unit that returns the angle of a point in centidegrees.

// A word is taken when start is high and busy is low; the angle comes back on
// angle_centideg for exactly one cycle with done high, and must be captured then.
// The coordinates live in two shift registers of COORD_WIDTH+3 bits that one
// serial adder each walks through, one bit per clock; a word runs up to ITERATIONS
// micro-rotations, fewer when y reaches zero early. A point whose y is zero
// returns angle 0 in the cycle after it is taken. A new word may be started in the
// cycle in which done is high.
module cordic_vectoring_angle #(
	parameter int ITERATIONS  = 10,
	parameter int COORD_WIDTH = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  logic signed [cva_pkg::IN_WIDTH-1:0]       x_coord,
	input  logic signed [cva_pkg::IN_WIDTH-1:0]       y_coord,
	output logic                                      busy,
	output logic                                      done,
	output logic signed [cva_pkg::ANGLE_WIDTH-1:0]    angle_centideg
);

	localparam int W         = COORD_WIDTH + 3;
	localparam int BW        = $clog2(W);
	localparam int IW        = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
	localparam bit SIGN_IN   = (COORD_WIDTH <= cva_pkg::IN_WIDTH);
	localparam int SIGN_POS  = SIGN_IN ? COORD_WIDTH - 1 : cva_pkg::IN_WIDTH - 1;

	cva_pkg::state_t state_q;
	logic [W-1:0]    x_q, y_q;
	logic [BW-1:0]   bit_q;
	logic [IW-1:0]   iter_q;
	logic            cw_q, cx_q, cy_q, xsg_q, ysg_q, yor_q, done_q;
	cva_pkg::angle_t angle_q, angle_out_q;

	logic [W-1:0]    x_ext, y_ext;
	logic [BW-1:0]   shift_idx;
	logic [BW:0]     reach;
	logic            past_top, first_bit, last_bit, last_iter;
	logic            xs, ys, x_add, y_add, cin_x, cin_y;
	logic [1:0]      x_sum, y_sum;
	logic            y_neg, y_zero, finish_now;
	cva_pkg::angle_t angle_next;
	logic            accept;

	// Low COORD_WIDTH bits of each coordinate, sign-extended to the working width.
	always_comb begin
		for (int k = 0; k < W; k++) begin
			if (k < COORD_WIDTH) begin
				x_ext[k] = (k < cva_pkg::IN_WIDTH) ? x_coord[k] : 1'b0;
				y_ext[k] = (k < cva_pkg::IN_WIDTH) ? y_coord[k] : 1'b0;
			end else begin
				x_ext[k] = SIGN_IN ? x_coord[SIGN_POS] : 1'b0;
				y_ext[k] = SIGN_IN ? y_coord[SIGN_POS] : 1'b0;
			end
		end
	end

	assign accept    = start && !busy;
	assign shift_idx = BW'(iter_q);
	assign reach     = {1'b0, bit_q} + {1'b0, shift_idx};
	assign past_top  = reach >= (BW+1)'(W);
	assign first_bit = bit_q == '0;
	assign last_bit  = bit_q == BW'(W - 1);
	assign last_iter = iter_q == IW'(ITERATIONS - 1);

	// Position iter_q of the rotating register holds bit (bit_q + iter_q) of the
	// old value until the new bits reach it; from then on the old sign stands in.
	assign xs = past_top ? xsg_q : x_q[shift_idx];
	assign ys = past_top ? ysg_q : y_q[shift_idx];

	assign x_add = cw_q ? ys : ~ys;
	assign y_add = cw_q ? ~xs : xs;
	assign cin_x = first_bit ? !cw_q : cx_q;
	assign cin_y = first_bit ? cw_q : cy_q;
	assign x_sum = {1'b0, x_q[0]} + {1'b0, x_add} + {1'b0, cin_x};
	assign y_sum = {1'b0, y_q[0]} + {1'b0, y_add} + {1'b0, cin_y};

	assign y_neg      = y_sum[0];
	assign y_zero     = !(y_sum[0] || (yor_q && !first_bit));
	assign finish_now = last_bit && (y_zero || last_iter);
	assign angle_next = cw_q ? angle_q + cva_pkg::atan_entry(4'(iter_q))
	                         : angle_q - cva_pkg::atan_entry(4'(iter_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cva_pkg::ST_IDLE;
			bit_q   <= '0;
			iter_q  <= '0;
			cw_q    <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				cva_pkg::ST_IDLE: begin
					if (accept) begin
						bit_q  <= '0;
						iter_q <= '0;
						cw_q   <= 1'b1;
						if (y_ext == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= cva_pkg::ST_RUN;
						end
					end
				end
				cva_pkg::ST_RUN: begin
					if (last_bit) begin
						bit_q <= '0;
						if (cw_q && y_neg) begin
							cw_q <= 1'b0;
						end else if (!cw_q && !y_neg && !y_zero) begin
							cw_q <= 1'b1;
						end
						if (finish_now) begin
							done_q  <= 1'b1;
							state_q <= cva_pkg::ST_IDLE;
						end else begin
							iter_q <= iter_q + IW'(1);
						end
					end else begin
						bit_q <= bit_q + BW'(1);
					end
				end
				default: state_q <= cva_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath: coordinate shift registers, serial carries and the angle sum.
	always_ff @(posedge clk) begin
		if (state_q == cva_pkg::ST_IDLE) begin
			if (accept) begin
				x_q     <= x_ext;
				y_q     <= y_ext;
				angle_q <= '0;
				if (y_ext == '0) begin
					angle_out_q <= '0;
				end
			end
		end else begin
			x_q   <= {x_sum[0], x_q[W-1:1]};
			y_q   <= {y_sum[0], y_q[W-1:1]};
			cx_q  <= x_sum[1];
			cy_q  <= y_sum[1];
			yor_q <= !y_zero;
			if (first_bit) begin
				xsg_q <= x_q[W-1];
				ysg_q <= y_q[W-1];
			end
			if (last_bit) begin
				angle_q <= angle_next;
				if (finish_now) begin
					angle_out_q <= angle_next;
				end
			end
		end
	end

	assign busy           = state_q == cva_pkg::ST_RUN;
	assign done           = done_q;
	assign angle_centideg = angle_out_q;

`ifndef SYNTHESIS
	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (iter_q <= IW'(ITERATIONS - 1)))
		else $error("rotation index beyond the last step");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (bit_q <= BW'(W - 1)))
		else $error("bit counter beyond the working width");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe raised while still rotating");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && finish_now) |=> (done && !busy))
		else $error("finished word did not return to idle with a result");

	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (y_ext != '0)) |=> (busy && !done))
		else $error("accepted word with nonzero y did not start rotating");
`endif

endmodule

### sim/tb_top.sv
// Self-checking testbench of the CORDIC vectoring angle unit against its own angle predictor.
module tb_top;

	localparam int ITERATIONS  = 10;
	localparam int COORD_WIDTH = 16;
	localparam int IN_WIDTH    = cva_pkg::IN_WIDTH;
	localparam int ANGLE_WIDTH = cva_pkg::ANGLE_WIDTH;
	localparam int ATAN_CD [10] = '{4500, 2657, 1404, 713, 358, 179, 90, 45, 22, 11};
	localparam int PHASE_IDLE [4] = '{0, 74, 0, 9};
	localparam int EDGE_VALS [5] = '{-32768, -1, 0, 1, 32767};
	localparam int WORDS_PER_PHASE = 475;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		int     x;
		int     y;
		bit     known;
		int     angle;
	} point_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic signed [IN_WIDTH-1:0]    x_coord;
	logic signed [IN_WIDTH-1:0]    y_coord;
	logic                          busy;
	logic                          done;
	logic signed [ANGLE_WIDTH-1:0] angle_centideg;

	// Travels with each word so the monitor can use a typed-in angle where there is one.
	bit              known_angle;
	cva_pkg::angle_t known_value;

	cva_pkg::angle_t pending_angles [$];
	int              angle_errors;
	int              idle_pct;

	point_row_t directed_rows [23] = '{
		'{0, 0, 1, 0},
		'{32767, 0, 1, 0},
		'{-32768, 0, 1, 0},
		'{-1, 0, 1, 0},
		'{1, 0, 1, 0},
		'{1, 1, 1, 4500},
		'{-1, -1, 1, 4500},
		'{32767, 32767, 1, 4500},
		'{-32768, -32768, 1, 4500},
		'{0, 32767, 0, 0},
		'{0, -32768, 0, 0},
		'{0, 1, 0, 0},
		'{0, -1, 0, 0},
		'{32767, -32768, 0, 0},
		'{-32768, 32767, 0, 0},
		'{-32768, 1, 0, 0},
		'{32767, 1, 0, 0},
		'{32767, -1, 0, 0},
		'{-32768, -1, 0, 0},
		'{2, 1, 0, 0},
		'{1, -1, 0, 0},
		'{-21846, 21845, 0, 0},
		'{21845, -21846, 0, 0}
	};

	cordic_vectoring_angle #(
		.ITERATIONS  (ITERATIONS),
		.COORD_WIDTH (COORD_WIDTH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.x_coord        (x_coord),
		.y_coord        (y_coord),
		.busy           (busy),
		.done           (done),
		.angle_centideg (angle_centideg)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("cordic_vectoring_angle: mismatch");
		$finish;
	end

	// Unrolled micro-rotations; x and y carry three guard bits as in the block.
	function automatic cva_pkg::angle_t predict_angle(input logic signed [IN_WIDTH-1:0] xin,
		input logic signed [IN_WIDTH-1:0] yin);
		logic signed [COORD_WIDTH+2:0] xr;
		logic signed [COORD_WIDTH+2:0] yr;
		logic signed [COORD_WIDTH+2:0] xs;
		logic signed [COORD_WIDTH+2:0] ys;
		cva_pkg::angle_t acc;
		bit     clockwise;
		xr = xin;
		yr = yin;
		acc = '0;
		clockwise = 1'b1;
		for (int i = 0; i < ITERATIONS && yr != 0; i++) begin
			xs = xr >>> i;
			ys = yr >>> i;
			if (clockwise) begin
				xr = xr + ys;
				yr = yr - xs;
				if (yr < 0)
					clockwise = 1'b0;
				acc = acc + cva_pkg::angle_t'(ATAN_CD[i]);
			end else begin
				xr = xr - ys;
				yr = yr + xs;
				if (yr > 0)
					clockwise = 1'b1;
				acc = acc - cva_pkg::angle_t'(ATAN_CD[i]);
			end
		end
		return acc;
	endfunction

	// Result check comes first: a word taken at this edge cannot finish at the same edge.
	always @(posedge clk) begin
		cva_pkg::angle_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_angles.size() == 0) begin
					if (angle_errors < 10)
						$display("unexpected angle %0d with no word pending", angle_centideg);
					angle_errors++;
				end else begin
					want = pending_angles.pop_front();
					if (angle_centideg !== want) begin
						if (angle_errors < 10)
							$display("angle error: expected %0d, got %0d", want, angle_centideg);
						angle_errors++;
					end
				end
			end
			if (start && !busy)
				pending_angles.push_back(known_angle ? known_value : predict_angle(x_coord, y_coord));
		end
	end

	task automatic send_word(input logic signed [IN_WIDTH-1:0] xv,
		input logic signed [IN_WIDTH-1:0] yv, input bit has_angle,
		input cva_pkg::angle_t angle_val);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		x_coord     <= xv;
		y_coord     <= yv;
		known_angle <= has_angle;
		known_value <= angle_val;
		do
			@(posedge clk);
		while (busy);
	endtask

	initial begin
		logic signed [IN_WIDTH-1:0] rx;
		logic signed [IN_WIDTH-1:0] ry;
		int pick;
		arst_n       = 1'b0;
		start        = 1'b0;
		x_coord      = '0;
		y_coord      = '0;
		known_angle  = 1'b0;
		known_value  = '0;
		angle_errors = 0;
		idle_pct     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_word(IN_WIDTH'(directed_rows[r].x), IN_WIDTH'(directed_rows[r].y),
				directed_rows[r].known, cva_pkg::angle_t'(directed_rows[r].angle));

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = PHASE_IDLE[ph];
			repeat (WORDS_PER_PHASE) begin
				pick = $urandom_range(9);
				case (pick)
					4: begin
						rx = IN_WIDTH'($urandom_range(16) - 8);
						ry = IN_WIDTH'($urandom_range(16) - 8);
					end
					5: begin
						rx = IN_WIDTH'($urandom);
						ry = '0;
					end
					6: begin
						ry = IN_WIDTH'($urandom);
						rx = $urandom_range(1) ? ry : -ry;
					end
					7: begin
						rx = IN_WIDTH'(EDGE_VALS[$urandom_range(4)]);
						ry = IN_WIDTH'(EDGE_VALS[$urandom_range(4)]);
					end
					8: begin
						rx = IN_WIDTH'($urandom);
						ry = IN_WIDTH'($urandom_range(64) - 32);
					end
					9: begin
						// Points close to a table angle drive y to zero after a few steps.
						rx = IN_WIDTH'($urandom);
						ry = rx >>> $urandom_range(10);
						if ($urandom_range(1))
							ry = -ry;
					end
					default: begin
						rx = IN_WIDTH'($urandom);
						ry = IN_WIDTH'($urandom);
					end
				endcase
				send_word(rx, ry, 1'b0, '0);
			end
		end
		start <= 1'b0;

		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (angle_errors == 0 && pending_angles.size() == 0)
			$display("cordic_vectoring_angle: match");
		else
			$display("cordic_vectoring_angle: mismatch");
		$finish;
	end

endmodule
